@@ hdl/lrcf_pkg.sv @@
// ----------------------------------------------------------------------------
// lrcf_pkg
// Types and constants shared by the led ring chase fader modules.
// ----------------------------------------------------------------------------
package lrcf_pkg;

   // field widths
   localparam int BRIGHT_W  = 17;   // brightness, unsigned Q9.8
   localparam int STEP_W    = 14;   // step, unsigned Q6.8
   localparam int GAIN_W    = 9;    // gain, 256 is unity
   localparam int LEVEL_W   = 16;   // pwm level
   localparam int TRIG_W    = 3;    // sound trigger count
   localparam int SQ_W      = 2 * BRIGHT_W;
   localparam int PROD_W    = SQ_W + GAIN_W;
   localparam int LVL_SHIFT = 24;

   // registers and reported leds
   localparam int NUM_GAINS = 6;
   localparam int NUM_OUT   = 6;
   localparam int CSR_IDX_W = 3;

   // brightness thresholds in Q9.8
   localparam logic [BRIGHT_W-1:0] PEAK_Q8    = 17'd65280;
   localparam logic [BRIGHT_W-1:0] RESTART_Q8 = 17'd32768;
   localparam logic [GAIN_W-1:0]   UNITY_GAIN = 9'd256;

   localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_GAINS] =
      '{9'd256, 9'd256, 9'd64, 9'd256, 9'd256, 9'd64};

   // led direction
   typedef enum logic [1:0] {
      DIR_OFF  = 2'd0,
      DIR_RISE = 2'd1,
      DIR_FALL = 2'd2
   } dir_type;

   // one entry of the led state memory
   typedef struct packed {
      dir_type                dir;
      logic [BRIGHT_W-1:0]    bright;
   } led_entry_type;

   // tick sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SEND
   } state_type;

endpackage

@@ hdl/lrcf_level.sv @@
// ----------------------------------------------------------------------------
// lrcf_level
// Two-stage level pipeline: squares the brightness, scales by the gain,
// drops 24 fraction bits and saturates to 16 bits.
// ----------------------------------------------------------------------------
module lrcf_level #(
   parameter int IDX_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic [IDX_W-1:0]              in_idx,
   input  logic [lrcf_pkg::BRIGHT_W-1:0] in_bright,
   input  logic [lrcf_pkg::GAIN_W-1:0]   in_gain,
   output logic                          out_vld,
   output logic [IDX_W-1:0]              out_idx,
   output logic [lrcf_pkg::LEVEL_W-1:0]  out_level
);

   logic                          sq_vld_ff;
   logic [IDX_W-1:0]              sq_idx_ff;
   logic [lrcf_pkg::SQ_W-1:0]     sq_ff;
   logic [lrcf_pkg::GAIN_W-1:0]   gain_ff;

   logic [lrcf_pkg::PROD_W-1:0]   prod;
   logic [lrcf_pkg::PROD_W-lrcf_pkg::LVL_SHIFT-1:0] prod_hi;
   logic [lrcf_pkg::LEVEL_W-1:0]  level_in;

   logic                          out_vld_ff;
   logic [IDX_W-1:0]              out_idx_ff;
   logic [lrcf_pkg::LEVEL_W-1:0]  out_level_ff;

   // valid tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff  <= in_vld;
         out_vld_ff <= sq_vld_ff;
      end
   end

   // square stage
   always_ff @(posedge clock) begin
      sq_ff     <= lrcf_pkg::SQ_W'(in_bright) * lrcf_pkg::SQ_W'(in_bright);
      gain_ff   <= in_gain;
      sq_idx_ff <= in_idx;
   end

   // gain scale and saturation
   always_comb begin
      prod    = lrcf_pkg::PROD_W'(sq_ff) * lrcf_pkg::PROD_W'(gain_ff);
      prod_hi = prod[lrcf_pkg::PROD_W-1:lrcf_pkg::LVL_SHIFT];
      if (prod_hi > {{(lrcf_pkg::PROD_W-lrcf_pkg::LVL_SHIFT-lrcf_pkg::LEVEL_W){1'b0}},
                     {lrcf_pkg::LEVEL_W{1'b1}}}) begin
         level_in = {lrcf_pkg::LEVEL_W{1'b1}};
      end else begin
         level_in = prod_hi[lrcf_pkg::LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      out_level_ff <= level_in;
      out_idx_ff   <= sq_idx_ff;
   end

   assign out_vld   = out_vld_ff;
   assign out_idx   = out_idx_ff;
   assign out_level = out_level_ff;

endmodule

@@ hdl/led_ring_chase_fader_top.sv @@
// ----------------------------------------------------------------------------
// led_ring_chase_fader_top
// Ring chase fader: one tick per input word, one level word per tick.
// ----------------------------------------------------------------------------
// The led state lives in a small state memory with one read port and one
// write port. It is walked one led per cycle in index order, read-modify-write,
// followed by a two-stage square and gain pipeline. A finished result waits in
// the output register, so the next tick is accepted while it is still held.
// The state memory needs no clearing pass: per-entry valid bits make unwritten
// entries read as their reset value.
module led_ring_chase_fader_top #(
   parameter int NUM_LEDS = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lrcf_pkg::STEP_W-1:0]    req_base_step,
   input  logic [lrcf_pkg::STEP_W-1:0]    req_override_step,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lrcf_pkg::LEVEL_W-1:0]   rsp_level0,
   output logic [lrcf_pkg::LEVEL_W-1:0]   rsp_level1,
   output logic [lrcf_pkg::LEVEL_W-1:0]   rsp_level2,
   output logic [lrcf_pkg::LEVEL_W-1:0]   rsp_level3,
   output logic [lrcf_pkg::LEVEL_W-1:0]   rsp_level4,
   output logic [lrcf_pkg::LEVEL_W-1:0]   rsp_level5,
   output logic [lrcf_pkg::TRIG_W-1:0]    rsp_sound_triggers,
   // register write port
   input  logic                           csr_write_en,
   input  logic [lrcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lrcf_pkg::GAIN_W-1:0]    csr_wdata
);

   localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

   // sequencer
   lrcf_pkg::state_type state_ff, state_in;
   logic req_accept;
   logic rsp_accept;
   logic rd_en;
   logic rsp_load;
   logic last_done;

   // registers
   logic [lrcf_pkg::GAIN_W-1:0] gain_ff [lrcf_pkg::NUM_GAINS];

   // tick context
   logic [lrcf_pkg::STEP_W-1:0] step_ff;
   logic [lrcf_pkg::TRIG_W-1:0] trig_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic                        rise_next_ff, rise_next_in;

   // state memory
   lrcf_pkg::led_entry_type mem [NUM_LEDS];
   lrcf_pkg::led_entry_type mem_q_ff;
   logic [NUM_LEDS-1:0]     entry_vld_ff;
   logic                    ent_vld_ff;
   logic                    s1_vld_ff;
   logic [IDX_W-1:0]        s1_idx_ff;

   // modify stage
   lrcf_pkg::led_entry_type  ent;
   lrcf_pkg::led_entry_type  ent_new;
   lrcf_pkg::dir_type        dir_eff;
   lrcf_pkg::dir_type        mid_dir;
   logic [lrcf_pkg::BRIGHT_W:0]   sum;
   logic [lrcf_pkg::BRIGHT_W-1:0] mid_b;
   logic [lrcf_pkg::BRIGHT_W-1:0] down;
   logic                          peak;

   // level stage
   logic                          s2_vld_ff;
   logic [IDX_W-1:0]              s2_idx_ff;
   logic [lrcf_pkg::BRIGHT_W-1:0] s2_b_ff;
   logic [lrcf_pkg::GAIN_W-1:0]   gain_sel;
   logic                          lv_vld;
   logic [IDX_W-1:0]              lv_idx;
   logic [lrcf_pkg::LEVEL_W-1:0]  lv_level;
   logic [lrcf_pkg::LEVEL_W-1:0]  lvl_ff [lrcf_pkg::NUM_OUT];

   // output register
   logic                          rsp_valid_ff;
   logic [lrcf_pkg::LEVEL_W-1:0]  rsp_lvl_ff [lrcf_pkg::NUM_OUT];
   logic [lrcf_pkg::TRIG_W-1:0]   rsp_trig_ff;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign last_done  = lv_vld && (lv_idx == LAST_IDX);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrcf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and control
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         lrcf_pkg::ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               state_in = lrcf_pkg::ST_RUN;
            end
         end
         lrcf_pkg::ST_RUN: begin
            rd_en = 1'b1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = lrcf_pkg::ST_DRAIN;
            end
         end
         lrcf_pkg::ST_DRAIN: begin
            if (last_done) begin
               state_in = lrcf_pkg::ST_SEND;
            end
         end
         lrcf_pkg::ST_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = lrcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrcf_pkg::ST_IDLE;
         end
      endcase
   end

   // gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lrcf_pkg::NUM_GAINS; i++) begin
            gain_ff[i] <= lrcf_pkg::GAIN_RESET[i];
         end
      end else if (csr_write_en &&
                   (csr_index < lrcf_pkg::CSR_IDX_W'(lrcf_pkg::NUM_GAINS))) begin
         gain_ff[csr_index] <= csr_wdata;
      end
   end

   // step select, read walk and trigger count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         trig_ff      <= '0;
         rise_next_ff <= 1'b0;
      end else begin
         rise_next_ff <= rise_next_in;
         if (req_accept) begin
            rd_idx_ff <= '0;
            trig_ff   <= '0;
         end else begin
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + IDX_W'(1);
            end
            if (s1_vld_ff && peak && (trig_ff != {lrcf_pkg::TRIG_W{1'b1}})) begin
               trig_ff <= trig_ff + lrcf_pkg::TRIG_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         step_ff <= (req_override_step != '0) ? req_override_step : req_base_step;
      end
   end

   // state memory read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff   <= mem[rd_idx_ff];
         ent_vld_ff <= entry_vld_ff[rd_idx_ff];
      end
      s1_idx_ff <= rd_idx_ff;
   end

   // state memory write port
   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         mem[s1_idx_ff] <= ent_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
         s2_vld_ff <= s1_vld_ff;
         if (s1_vld_ff) begin
            entry_vld_ff[s1_idx_ff] <= 1'b1;
         end
      end
   end

   // modify: rise, peak handoff, fall and clamp
   always_comb begin
      if (ent_vld_ff) begin
         ent = mem_q_ff;
      end else begin
         ent.bright = '0;
         ent.dir    = (s1_idx_ff == '0) ? lrcf_pkg::DIR_RISE : lrcf_pkg::DIR_OFF;
      end
      dir_eff = rise_next_ff ? lrcf_pkg::DIR_RISE : ent.dir;
      sum     = {1'b0, ent.bright} + (lrcf_pkg::BRIGHT_W + 1)'(step_ff);
      down    = {{(lrcf_pkg::BRIGHT_W - lrcf_pkg::STEP_W - 1){1'b0}}, step_ff, 1'b0};
      peak    = (dir_eff == lrcf_pkg::DIR_RISE) &&
                (sum > {1'b0, lrcf_pkg::PEAK_Q8});
      if (peak) begin
         mid_b   = lrcf_pkg::RESTART_Q8;
         mid_dir = lrcf_pkg::DIR_FALL;
      end else if (dir_eff == lrcf_pkg::DIR_RISE) begin
         mid_b   = sum[lrcf_pkg::BRIGHT_W-1:0];
         mid_dir = lrcf_pkg::DIR_RISE;
      end else begin
         mid_b   = ent.bright;
         mid_dir = dir_eff;
      end
      ent_new.bright = mid_b;
      ent_new.dir    = mid_dir;
      if (mid_dir == lrcf_pkg::DIR_FALL) begin
         if (down >= mid_b) begin
            ent_new.bright = '0;
            ent_new.dir    = lrcf_pkg::DIR_OFF;
         end else begin
            ent_new.bright = mid_b - down;
         end
      end
      // rising handoff carries to the next led, and across the wrap to the next tick
      rise_next_in = s1_vld_ff ? peak : rise_next_ff;
   end

   always_ff @(posedge clock) begin
      s2_b_ff   <= ent_new.bright;
      s2_idx_ff <= s1_idx_ff;
   end

   // gain for the led in the level pipeline
   always_comb begin
      gain_sel = lrcf_pkg::UNITY_GAIN;
      for (int i = 0; i < NUM_LEDS; i++) begin
         if ((i < lrcf_pkg::NUM_GAINS) && (s2_idx_ff == IDX_W'(i))) begin
            gain_sel = gain_ff[i % lrcf_pkg::NUM_GAINS];
         end
      end
   end

   lrcf_level #(
      .IDX_W (IDX_W)
   ) u_level (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (s2_vld_ff),
      .in_idx    (s2_idx_ff),
      .in_bright (s2_b_ff),
      .in_gain   (gain_sel),
      .out_vld   (lv_vld),
      .out_idx   (lv_idx),
      .out_level (lv_level)
   );

   // per-led level collection, absent leds read zero
   for (genvar g = 0; g < lrcf_pkg::NUM_OUT; g++) begin : g_lvl
      if (g < NUM_LEDS) begin : g_used
         always_ff @(posedge clock) begin
            if (lv_vld && (lv_idx == IDX_W'(g))) begin
               lvl_ff[g] <= lv_level;
            end
         end
      end else begin : g_absent
         assign lvl_ff[g] = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int i = 0; i < lrcf_pkg::NUM_OUT; i++) begin
            rsp_lvl_ff[i] <= lvl_ff[i];
         end
         rsp_trig_ff <= trig_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level0         = rsp_lvl_ff[0];
   assign rsp_level1         = rsp_lvl_ff[1];
   assign rsp_level2         = rsp_lvl_ff[2];
   assign rsp_level3         = rsp_lvl_ff[3];
   assign rsp_level4         = rsp_lvl_ff[4];
   assign rsp_level5         = rsp_lvl_ff[5];
   assign rsp_sound_triggers = rsp_trig_ff;

endmodule

@@ hdl/lrcf_check.sv @@
// ----------------------------------------------------------------------------
// lrcf_check
// Port-level checks for the led ring chase fader, bound to the top level.
// ----------------------------------------------------------------------------
module lrcf_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lrcf_pkg::LEVEL_W-1:0]  rsp_level0,
   input logic [lrcf_pkg::LEVEL_W-1:0]  rsp_level5,
   input logic [lrcf_pkg::TRIG_W-1:0]   rsp_sound_triggers
);

   // a held response word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level0) &&
         $stable(rsp_level5) && $stable(rsp_sound_triggers))
      else $error("response word changed while stalled");

   // an accepted tick keeps the request channel stalled in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on the cycle after a tick was accepted");

   // a new response only appears at the end of a tick's walk
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a tick in progress");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind led_ring_chase_fader_top lrcf_check u_lrcf_check (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the led ring chase fader. A shadow copy of the
// ring (brightness, direction, gains) predicts the level word of every tick
// word that is taken. Level words are checked field by field in arrival
// order. Both channels idle and stall at random. The run covers step
// extremes, gain extremes with unused register indexes, a long output
// hold-off and several random chase phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int RING_LEDS      = 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASES         = 6;
   localparam int TICKS_PER_PHASE = 100;

   // one level word as the block reports it
   typedef struct packed {
      logic [lrcf_pkg::NUM_OUT-1:0][lrcf_pkg::LEVEL_W-1:0] level;
      logic [lrcf_pkg::TRIG_W-1:0]                         triggers;
   } level_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [lrcf_pkg::STEP_W-1:0]     req_base_step = '0;
   logic [lrcf_pkg::STEP_W-1:0]     req_override_step = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [lrcf_pkg::LEVEL_W-1:0]    rsp_level0, rsp_level1, rsp_level2;
   logic [lrcf_pkg::LEVEL_W-1:0]    rsp_level3, rsp_level4, rsp_level5;
   logic [lrcf_pkg::TRIG_W-1:0]     rsp_sound_triggers;
   logic                            csr_write_en = 1'b0;
   logic [lrcf_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lrcf_pkg::GAIN_W-1:0]     csr_wdata = '0;

   // shadow state of the ring
   logic [lrcf_pkg::BRIGHT_W-1:0]   led_bright [RING_LEDS];
   lrcf_pkg::dir_type               led_dir [RING_LEDS];
   logic [lrcf_pkg::GAIN_W-1:0]     gain_shadow [lrcf_pkg::NUM_GAINS];
   logic [lrcf_pkg::GAIN_W-1:0]     gain_plan [lrcf_pkg::NUM_GAINS];

   level_word_type        pending_words [$];
   level_word_type        want_word, got_word;

   int  tick_count   = 0;
   int  word_count   = 0;
   int  error_count  = 0;
   int  peak_total   = 0;
   int  gain_loads   = 0;
   int  idle_cycles  = 0;
   bit  gaps_on      = 1'b1;
   int  hold_request = 0;
   int  hold_left    = 0;
   int  stall_left   = 0;

   led_ring_chase_fader_top #(
      .NUM_LEDS (RING_LEDS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_base_step      (req_base_step),
      .req_override_step  (req_override_step),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level0         (rsp_level0),
      .rsp_level1         (rsp_level1),
      .rsp_level2         (rsp_level2),
      .rsp_level3         (rsp_level3),
      .rsp_level4         (rsp_level4),
      .rsp_level5         (rsp_level5),
      .rsp_sound_triggers (rsp_sound_triggers),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // gap length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // gain choice weighted toward the extremes
   function automatic logic [lrcf_pkg::GAIN_W-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 35) return lrcf_pkg::UNITY_GAIN;
      if (r < 45) return '1;
      if (r < 55) return lrcf_pkg::GAIN_W'($urandom_range(257, 511));
      return lrcf_pkg::GAIN_W'($urandom_range(0, 256));
   endfunction

   // advance the shadow ring by one tick and form the level word
   function automatic level_word_type advance_ring(
      input logic [lrcf_pkg::STEP_W-1:0] base,
      input logic [lrcf_pkg::STEP_W-1:0] over);
      logic [lrcf_pkg::STEP_W-1:0]   step;
      logic [lrcf_pkg::STEP_W:0]     down;
      logic [lrcf_pkg::BRIGHT_W-1:0] sum;
      logic [lrcf_pkg::PROD_W-1:0]   prod;
      logic [lrcf_pkg::GAIN_W-1:0]   g;
      int                            nxt;
      int                            peaks;
      level_word_type                w;
      step  = (over != '0) ? over : base;
      down  = {step, 1'b0};
      peaks = 0;
      w     = '0;
      for (int i = 0; i < RING_LEDS; i++) begin
         nxt = (i == RING_LEDS - 1) ? 0 : i + 1;
         // rising led gains a step, peaks hand over to the next led
         if (led_dir[i] == lrcf_pkg::DIR_RISE) begin
            sum = led_bright[i] + step;
            if (sum > lrcf_pkg::PEAK_Q8) begin
               sum          = lrcf_pkg::RESTART_Q8;
               led_dir[i]   = lrcf_pkg::DIR_FALL;
               led_dir[nxt] = lrcf_pkg::DIR_RISE;
               peaks++;
            end
            led_bright[i] = sum;
         end
         // falling led loses twice the step, clamps to off
         if (led_dir[i] == lrcf_pkg::DIR_FALL) begin
            if (down >= led_bright[i]) begin
               led_bright[i] = '0;
               led_dir[i]    = lrcf_pkg::DIR_OFF;
            end else begin
               led_bright[i] = led_bright[i] - down;
            end
         end
      end
      for (int i = 0; i < lrcf_pkg::NUM_OUT; i++) begin
         if (i < RING_LEDS) begin
            g    = (i < lrcf_pkg::NUM_GAINS) ? gain_shadow[i] : lrcf_pkg::UNITY_GAIN;
            prod = led_bright[i] * led_bright[i] * g;
            prod = prod >> lrcf_pkg::LVL_SHIFT;
            w.level[i] = (prod > 'hFFFF) ? 16'hFFFF : prod[lrcf_pkg::LEVEL_W-1:0];
         end
      end
      w.triggers = (peaks > 7) ? 3'd7 : lrcf_pkg::TRIG_W'(peaks);
      peak_total += peaks;
      return w;
   endfunction

   // offer one tick word and wait until it is taken
   task automatic send_tick(input logic [lrcf_pkg::STEP_W-1:0] base,
                            input logic [lrcf_pkg::STEP_W-1:0] over);
      int gap;
      req_valid         <= 1'b1;
      req_base_step     <= base;
      req_override_step <= over;
      do @(posedge clock); while (req_stall);
      pending_words.push_back(advance_ring(base, over));
      tick_count++;
      gap = (gaps_on && $urandom_range(0, 99) >= 45) ? gap_len() : 0;
      if (gap > 0) begin
         req_valid         <= 1'b0;
         req_base_step     <= lrcf_pkg::STEP_W'($urandom);
         req_override_step <= lrcf_pkg::STEP_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding level word
   task automatic drain_ticks();
      req_valid <= 1'b0;
      wait (pending_words.size() == 0);
      @(posedge clock);
   endtask

   // write the planned gains, optionally also an index past the last gain
   task automatic load_gains(input bit poke_unused);
      int n;
      n = poke_unused ? lrcf_pkg::NUM_GAINS + 1 : lrcf_pkg::NUM_GAINS;
      for (int i = 0; i < n; i++) begin
         csr_write_en <= 1'b1;
         if (i < lrcf_pkg::NUM_GAINS) begin
            csr_index <= lrcf_pkg::CSR_IDX_W'(i);
            csr_wdata <= gain_plan[i];
         end else begin
            csr_index <= lrcf_pkg::CSR_IDX_W'(lrcf_pkg::NUM_GAINS + $urandom_range(0, 1));
            csr_wdata <= lrcf_pkg::GAIN_W'($urandom);
         end
         @(posedge clock);
         if (i < lrcf_pkg::NUM_GAINS) gain_shadow[i] = gain_plan[i];
      end
      csr_write_en <= 1'b0;
      gain_loads++;
   endtask

   // random tick, mostly steps big enough to keep the chase moving
   task automatic send_random_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         send_tick('0, '0);
      else if (r < 15)
         send_tick(lrcf_pkg::STEP_W'($urandom_range(0, 15)), '0);
      else if (r < 70)
         send_tick(lrcf_pkg::STEP_W'($urandom_range(1024, 16383)), '0);
      else if (r < 85)
         send_tick(lrcf_pkg::STEP_W'($urandom),
                   lrcf_pkg::STEP_W'($urandom_range(1, 16383)));
      else
         send_tick(lrcf_pkg::STEP_W'($urandom),
                   $urandom_range(0, 1) ? '0 : lrcf_pkg::STEP_W'($urandom));
   endtask

   // step extremes with reset gains, override against base
   task automatic test_step_extremes();
      send_tick('0, '0);
      send_tick('0, '0);
      send_tick('1, '0);
      send_tick('0, '1);
      send_tick('1, '1);
      send_tick(14'd1, '0);
      send_tick('0, 14'd1);
      send_tick(14'd5000, 14'd300);
      drain_ticks();
   endtask

   // gain extremes, unused index write, peaks then zero step hold
   task automatic test_gain_extremes();
      gain_plan = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd255, 9'd257};
      load_gains(1'b1);
      repeat (4) send_tick('1, '0);
      send_tick('0, '0);
      send_tick('0, '0);
      repeat (8) send_tick('0, '1);
      drain_ticks();
   endtask

   // long output hold-off while the sender keeps offering
   task automatic test_output_hold();
      gaps_on      = 1'b0;
      hold_request = 400;
      repeat (16) send_random_tick();
      gaps_on = 1'b1;
      drain_ticks();
   endtask

   // random chase phases, each with fresh gains and a drain midway
   task automatic test_random_chase();
      for (int p = 0; p < PHASES; p++) begin
         for (int i = 0; i < lrcf_pkg::NUM_GAINS; i++) gain_plan[i] = pick_gain();
         load_gains($urandom_range(0, 1));
         gaps_on = (p != 2);
         for (int t = 0; t < TICKS_PER_PHASE; t++) begin
            send_random_tick();
            if (t == TICKS_PER_PHASE / 2) drain_ticks();
         end
         drain_ticks();
      end
      gaps_on = 1'b1;
   endtask

   // level word checker and output stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word.level    = {rsp_level5, rsp_level4, rsp_level3,
                              rsp_level2, rsp_level1, rsp_level0};
         got_word.triggers = rsp_sound_triggers;
         if (pending_words.size() == 0) begin
            $display("%0t: level word expected none, actual %h", $time, got_word);
            error_count++;
         end else begin
            want_word = pending_words.pop_front();
            word_count++;
            for (int i = 0; i < lrcf_pkg::NUM_OUT; i++) begin
               if (got_word.level[i] !== want_word.level[i]) begin
                  $display("%0t: level%0d expected %0d actual %0d", $time, i,
                           want_word.level[i], got_word.level[i]);
                  error_count++;
               end
            end
            if (got_word.triggers !== want_word.triggers) begin
               $display("%0t: sound_triggers expected %0d actual %0d", $time,
                        want_word.triggers, got_word.triggers);
               error_count++;
            end
         end
      end
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!gaps_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 99) < 30) begin
         stall_left = gap_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d words outstanding", $time,
                  idle_cycles, pending_words.size());
         $display("tb: errors");
         $finish;
      end
   end

   // test sequence
   initial begin
      for (int i = 0; i < RING_LEDS; i++) begin
         led_bright[i] = '0;
         led_dir[i]    = lrcf_pkg::DIR_OFF;
      end
      led_dir[0] = lrcf_pkg::DIR_RISE;
      for (int i = 0; i < lrcf_pkg::NUM_GAINS; i++) gain_shadow[i] = lrcf_pkg::GAIN_RESET[i];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_step_extremes();
      test_gain_extremes();
      test_output_hold();
      test_random_chase();

      drain_ticks();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("summary: %0d ticks sent, %0d level words checked, %0d led peaks seen",
               tick_count, word_count, peak_total);
      $display("summary: %0d gain loads, random stalls, one long output hold-off",
               gain_loads);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
